FILE: rtl/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types and constants of the per-user segmenter: field widths,
// operation codes and the request payloads of both channels.
// ----------------------------------------------------------------------------
package psg_pkg;

  localparam int unsigned USER_W = 4;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned POS_W  = 4;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_FLUSH  = 1'b1
  } psg_op_e;

  typedef struct packed {
    psg_op_e             operation;
    logic [USER_W-1:0]   user;
    logic [BYTE_W-1:0]   data_byte;
  } psg_in_t;

  typedef struct packed {
    logic [USER_W-1:0]   out_user;
    logic [SEQ_W-1:0]    sequence_number;
    logic [BYTE_W-1:0]   out_byte;
    logic [POS_W-1:0]    position;
    logic                last;
  } psg_out_t;

endpackage

FILE: rtl/psg_ifs.sv
// ----------------------------------------------------------------------------
// psg_ifs
// Valid/ready channels of the per-user segmenter, one for the incoming
// requests and one for the emitted segment bytes.
// ----------------------------------------------------------------------------
interface psg_in_if import psg_pkg::*;;
  logic    valid;
  logic    ready;
  psg_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface psg_out_if import psg_pkg::*;;
  logic     valid;
  logic     ready;
  psg_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/psg_meta_store.sv
// ----------------------------------------------------------------------------
// psg_meta_store
// Per-user metadata memory holding the fill count and the sequence number.
// One synchronous read port and one write port; entries that have never
// been written read as zero through a valid bit per entry.
// ----------------------------------------------------------------------------
module psg_meta_store import psg_pkg::*; #(
  parameter int unsigned MAX_USERS = 8,
  parameter int unsigned FILL_W    = 5,
  localparam int unsigned SLOT_W   = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [SLOT_W-1:0]     rd_slot_i,
  output logic [FILL_W-1:0]     rd_fill_o,
  output logic [SEQ_W-1:0]      rd_seq_o,
  input  logic                  wr_en_i,
  input  logic [SLOT_W-1:0]     wr_slot_i,
  input  logic [FILL_W-1:0]     wr_fill_i,
  input  logic [SEQ_W-1:0]      wr_seq_i
);

  logic [FILL_W-1:0]    fill_mem [MAX_USERS];
  logic [SEQ_W-1:0]     seq_mem  [MAX_USERS];
  logic [MAX_USERS-1:0] vld_q;
  logic [FILL_W-1:0]    fill_rd_q;
  logic [SEQ_W-1:0]     seq_rd_q;
  logic                 vld_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_slot_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      fill_mem[wr_slot_i] <= wr_fill_i;
      seq_mem[wr_slot_i]  <= wr_seq_i;
    end
    if (rd_en_i) begin
      fill_rd_q <= fill_mem[rd_slot_i];
      seq_rd_q  <= seq_mem[rd_slot_i];
      vld_rd_q  <= vld_q[rd_slot_i];
    end
  end

  // An entry that has not been written since reset reads as zero.
  assign rd_fill_o = vld_rd_q ? fill_rd_q : '0;
  assign rd_seq_o  = vld_rd_q ? seq_rd_q  : '0;

endmodule

FILE: rtl/per_user_segmenter.sv
// ----------------------------------------------------------------------------
// per_user_segmenter
// Collects payload bytes per user into fixed-size segments and emits each
// completed or flushed segment byte by byte with its sequence number.
// ----------------------------------------------------------------------------
// A request is first accepted while the user's metadata entry is read; the
// entry is then updated and the byte written into the segment memory. A
// request that completes a segment, or a flush of a non-empty store, then
// streams the segment out through the single read port of the segment
// memory; each read waits until the previous one has returned and the output
// register is free, and intake pauses until the last byte has been read. The
// last byte may still wait in the output register while the next request is
// taken. There is no clearing pass after reset: metadata entries carry valid
// bits, and segment bytes are only read below the user's fill count. Requests
// for user 0 or a user above MAX_USERS are accepted and dropped.
// ----------------------------------------------------------------------------
module per_user_segmenter import psg_pkg::*; #(
  parameter int unsigned SEGMENT_BYTES = 16,
  parameter int unsigned MAX_USERS     = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psg_in_if.sink    in_i,
  psg_out_if.source out_o
);

  localparam int unsigned SLOT_W = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int unsigned FILL_W = $clog2(SEGMENT_BYTES + 1);
  localparam int unsigned DEPTH  = MAX_USERS * SEGMENT_BYTES;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_META,
    ST_EMIT
  } state_e;

  state_e              state_q;
  psg_op_e             op_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [BYTE_W-1:0]   byte_q;
  logic [FILL_W-1:0]   emit_len_q;
  logic [FILL_W-1:0]   emit_cnt_q;
  logic [SEQ_W-1:0]    emit_seq_q;
  logic                rd_pend_q;
  psg_out_t            rd_info_q;
  psg_out_t            rd_out;
  psg_out_t            out_q;
  logic                out_valid_q;

  logic                in_fire;
  logic                user_ok;
  logic [USER_W-1:0]   user_m1;
  logic [SLOT_W-1:0]   in_slot;

  logic [FILL_W-1:0]   meta_fill;
  logic [SEQ_W-1:0]    meta_seq;
  logic                meta_we;
  logic [FILL_W-1:0]   meta_wfill;
  logic [SEQ_W-1:0]    meta_wseq;

  logic [FILL_W-1:0]   fill_eff;
  logic [FILL_W-1:0]   app_fill;
  logic [SEQ_W-1:0]    seq_inc;
  logic                go_emit;
  logic [FILL_W-1:0]   go_len;

  logic                seg_we;
  logic [ADDR_W-1:0]   seg_waddr;
  logic                seg_re;
  logic [ADDR_W-1:0]   seg_raddr;
  logic [BYTE_W-1:0]   seg_mem [DEPTH];
  logic [BYTE_W-1:0]   seg_rdata_q;
  logic                emit_last;

  // Input side.
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign user_ok    = (in_i.payload.user != '0)
                      && (32'(in_i.payload.user) <= MAX_USERS);
  assign user_m1    = in_i.payload.user - USER_W'(1);
  assign in_slot    = SLOT_W'(user_m1);

  psg_meta_store #(
    .MAX_USERS (MAX_USERS),
    .FILL_W    (FILL_W)
  ) u_meta (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire && user_ok),
    .rd_slot_i (in_slot),
    .rd_fill_o (meta_fill),
    .rd_seq_o  (meta_seq),
    .wr_en_i   (meta_we),
    .wr_slot_i (slot_q),
    .wr_fill_i (meta_wfill),
    .wr_seq_i  (meta_wseq)
  );

  // Metadata update of the request under way.
  always_comb begin
    fill_eff   = (32'(meta_fill) >= SEGMENT_BYTES) ? '0 : meta_fill;
    app_fill   = fill_eff + FILL_W'(1);
    seq_inc    = meta_seq + SEQ_W'(1);
    meta_we    = 1'b0;
    meta_wfill = '0;
    meta_wseq  = meta_seq;
    seg_we     = 1'b0;
    seg_waddr  = ADDR_W'(32'(slot_q) * SEGMENT_BYTES + 32'(fill_eff));
    go_emit    = 1'b0;
    go_len     = '0;
    if (state_q == ST_META) begin
      case (op_q)
        OP_APPEND: begin
          seg_we  = 1'b1;
          meta_we = 1'b1;
          if (app_fill == FILL_W'(SEGMENT_BYTES)) begin
            meta_wseq = seq_inc;
            go_emit   = 1'b1;
            go_len    = app_fill;
          end else begin
            meta_wfill = app_fill;
          end
        end
        OP_FLUSH: begin
          if (meta_fill != '0) begin
            meta_we   = 1'b1;
            meta_wseq = seq_inc;
            go_emit   = 1'b1;
            go_len    = meta_fill;
          end
        end
        default: begin
          meta_we = 1'b0;
        end
      endcase
    end
  end

  // A read is only issued when the output register is free by the time the
  // data comes back.
  assign seg_re    = (state_q == ST_EMIT) && !rd_pend_q && (!out_valid_q || out_o.ready);
  assign seg_raddr = ADDR_W'(32'(slot_q) * SEGMENT_BYTES + 32'(emit_cnt_q));
  assign emit_last = (emit_cnt_q + FILL_W'(1)) == emit_len_q;

  always_ff @(posedge clk_i) begin
    if (seg_we) begin
      seg_mem[seg_waddr] <= byte_q;
    end
    if (seg_re) begin
      seg_rdata_q <= seg_mem[seg_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      emit_cnt_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_fire && user_ok) begin
            state_q <= ST_META;
          end
        end
        ST_META: begin
          if (go_emit) begin
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (seg_re) begin
            emit_cnt_q <= emit_cnt_q + FILL_W'(1);
            if (emit_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (state_q == ST_META) begin
        emit_cnt_q <= '0;
      end

      rd_pend_q <= seg_re;
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The returning byte joins the fields captured along with its read.
  always_comb begin
    rd_out          = rd_info_q;
    rd_out.out_byte = seg_rdata_q;
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= in_i.payload.operation;
      slot_q <= in_slot;
      byte_q <= in_i.payload.data_byte;
    end
    if (go_emit) begin
      emit_len_q <= go_len;
      emit_seq_q <= seq_inc;
    end
    if (seg_re) begin
      rd_info_q.out_user        <= USER_W'(32'(slot_q) + 1);
      rd_info_q.sequence_number <= emit_seq_q;
      rd_info_q.out_byte        <= '0;
      rd_info_q.position        <= POS_W'(emit_cnt_q);
      rd_info_q.last            <= emit_last;
    end
    if (rd_pend_q) begin
      out_q <= rd_out;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // The output register is always empty when a read returns.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !out_valid_q)
    else $error("segment read returned while output register was occupied");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (emit_cnt_q < emit_len_q))
    else $error("emission counter ran past the segment length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta_we |-> (32'(meta_wfill) < SEGMENT_BYTES))
    else $error("stored fill count reached a full segment");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_emit |=> (emit_len_q != '0))
    else $error("empty segment scheduled for emission");

endmodule

FILE: sim/tb_per_user_segmenter.sv
// ----------------------------------------------------------------------------
// tb_per_user_segmenter
// Self-checking testbench of the per-user segmenter. A scoreboard keeps its
// own per-user segment stores, fill counts and sequence numbers, predicts the
// segment bytes of every accepted request and checks each emitted byte in
// order. Directed requests and random traffic run under several idling
// patterns on both channels.
// ----------------------------------------------------------------------------
module tb_per_user_segmenter;
  import psg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SEG_BYTES   = 16;
  localparam int unsigned USERS       = 8;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned MAX_SHOWN   = 10;

  class segment_scoreboard;
    logic [BYTE_W-1:0] seg_store [USERS][SEG_BYTES];
    int unsigned       fill      [USERS];
    logic [SEQ_W-1:0]  seq_num   [USERS];
    psg_out_t          expected_bytes [$];
    int unsigned       failures;

    function new();
      foreach (fill[u]) begin
        fill[u]    = 0;
        seq_num[u] = '0;
      end
      failures = 0;
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    function void emit_segment(int unsigned slot);
      psg_out_t seg_byte;
      seq_num[slot] = seq_num[slot] + 1'b1;
      for (int unsigned k = 0; k < fill[slot]; k++) begin
        seg_byte.out_user        = USER_W'(slot + 1);
        seg_byte.sequence_number = seq_num[slot];
        seg_byte.out_byte        = seg_store[slot][k];
        seg_byte.position        = POS_W'(k);
        seg_byte.last            = (k + 1 == fill[slot]);
        expected_bytes.push_back(seg_byte);
      end
      fill[slot] = 0;
    endfunction

    function void note_request(psg_in_t req);
      int unsigned slot;
      // Requests for users outside the configured range change nothing.
      if (req.user < 1 || req.user > USERS) return;
      slot = req.user - 1;
      if (req.operation == OP_FLUSH) begin
        if (fill[slot] != 0) emit_segment(slot);
      end else begin
        if (fill[slot] >= SEG_BYTES) fill[slot] = 0;
        seg_store[slot][fill[slot]] = req.data_byte;
        fill[slot]++;
        if (fill[slot] == SEG_BYTES) emit_segment(slot);
      end
    endfunction

    function void check_byte(psg_out_t got);
      psg_out_t exp_byte;
      if (expected_bytes.size() == 0) begin
        failures++;
        if (failures <= MAX_SHOWN)
          $display("unexpected byte: user %0d seq %0d byte %02h pos %0d last %0b",
                   got.out_user, got.sequence_number, got.out_byte, got.position,
                   got.last);
        return;
      end
      exp_byte = expected_bytes.pop_front();
      if (got.out_user !== exp_byte.out_user ||
          got.sequence_number !== exp_byte.sequence_number ||
          got.out_byte !== exp_byte.out_byte ||
          got.position !== exp_byte.position ||
          got.last !== exp_byte.last) begin
        failures++;
        if (failures <= MAX_SHOWN)
          $display({"mismatch: expected user %0d seq %0d byte %02h pos %0d last %0b,",
                    " got user %0d seq %0d byte %02h pos %0d last %0b"},
                   exp_byte.out_user, exp_byte.sequence_number, exp_byte.out_byte,
                   exp_byte.position, exp_byte.last, got.out_user,
                   got.sequence_number, got.out_byte, got.position, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  psg_in_if  in_if ();
  psg_out_if out_if ();

  per_user_segmenter #(
    .SEGMENT_BYTES (SEG_BYTES),
    .MAX_USERS     (USERS)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  segment_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles    = 0;
  int unsigned cycle_count    = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    out_if.ready  = 1'b0;
    rst_n         = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Receiver: a long hold-off, when requested, takes precedence over the
  // random stalling of the current phase.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles  <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_byte(out_if.payload);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_request(psg_op_e op, logic [USER_W-1:0] user,
                              logic [BYTE_W-1:0] data);
    psg_in_t req;
    req.operation = op;
    req.user      = user;
    req.data_byte = data;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= req;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(req);
    @(negedge clk);
  endtask

  task automatic send_random_request();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      // Noise: users outside the range, either operation.
      send_request(psg_op_e'($urandom_range(1)),
                   ($urandom_range(1) != 0) ? USER_W'(0) : USER_W'($urandom_range(15, 9)),
                   BYTE_W'($urandom_range(255)));
    end else if (pick < 16) begin
      send_request(OP_FLUSH, USER_W'($urandom_range(USERS, 1)),
                   BYTE_W'($urandom_range(255)));
    end else begin
      send_request(OP_APPEND, USER_W'($urandom_range(USERS, 1)),
                   BYTE_W'($urandom_range(255)));
    end
  endtask

  // The sender stops until every predicted byte has come out.
  task automatic drain_outputs();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    @(posedge rst_n);
    @(negedge clk);

    // Directed requests: ignored users, flush of an empty store, a one-byte
    // segment and a full segment carrying the byte extremes.
    send_request(OP_APPEND, 4'd0, 8'hFF);
    send_request(OP_FLUSH, 4'd15, 8'h00);
    send_request(OP_APPEND, 4'd9, 8'hA5);
    send_request(OP_FLUSH, 4'd3, 8'h00);
    send_request(OP_APPEND, 4'd8, 8'hFF);
    send_request(OP_FLUSH, 4'd8, 8'h5A);
    for (int unsigned k = 0; k < SEG_BYTES; k++)
      send_request(OP_APPEND, 4'd1, BYTE_W'(k * 17));
    send_request(OP_FLUSH, 4'd1, 8'h00);
    drain_outputs();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 57;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 57;
          // Long hold-off so that the block fills up and stalls its input.
          hold_cycles    = 400;
        end
        default: begin
          send_idle_pct  = 30;
          recv_stall_pct = 30;
        end
      endcase
      for (int n = 0; n < 87; n++) send_random_request();
      drain_outputs();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (60) @(negedge clk);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
